/* rtl/core/mdcm_pkg.sv */
// shared types, register indexes and the sine table builder for the chorus mixer
package mdcm_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_ADDR,
        S_INTERP,
        S_WET,
        S_MIX
    } mdcm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic modulate;
        logic addr;
        logic interp;
        logic blend;
        logic finish;
    } mdcm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } mdcm_stat_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_INPUT_GAIN   = 3'd0;
    localparam logic [2:0] REG_DRIFT_DEPTH  = 3'd1;
    localparam logic [2:0] REG_WOBBLE_DEPTH = 3'd2;
    localparam logic [2:0] REG_EFFECT_MIX   = 3'd3;
    localparam logic [2:0] REG_DRIFT_STEP   = 3'd4;
    localparam logic [2:0] REG_WOBBLE_STEP  = 3'd5;

    // reset values
    localparam logic [15:0] GAIN_RESET        = 16'd16384;
    localparam logic [14:0] MIX_RESET         = 15'd1081;
    localparam logic [23:0] DRIFT_STEP_RESET  = 24'd37;
    localparam logic [23:0] WOBBLE_STEP_RESET = 24'd175;

    // chorus runs above this depth code
    localparam logic [15:0] ACTIVE_THRESHOLD = 16'd4;
    // reciprocal of 5 in Q22, exact for the wet sum range
    localparam logic [19:0] WET_RECIP = 20'd838861;
    localparam logic [14:0] WET_MAX   = 15'd16384;
    // base delay of ten samples in Q16
    localparam logic signed [39:0] DELAY_BASE = 40'sd655360;

    // saturate to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)
            r = 16'sd32767;
        else if (v < -40'sd32768)
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    // one sine table entry, quarter wave polynomial, evaluated at elaboration
    function automatic logic signed [15:0] sine_entry(input int idx, input int bits);
        logic [63:0] size;
        logic [63:0] four;
        logic [63:0] q;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] s;
        logic [15:0] v;
        size = 64'd1 << bits;
        four = 64'(idx) << 2;
        q = four >> bits;
        f = four & (size - 64'd1);
        if (q[0])
            f = size - f;
        t = (f << 30) >> bits;
        t2 = (t * t) >> 30;
        r = 64'd5026938;
        r = 64'd85569278 - ((r * t2) >> 30);
        r = 64'd693598671 - ((r * t2) >> 30);
        r = 64'd1686629713 - ((r * t2) >> 30);
        s = (r * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
            s = 64'd32767;
        v = s[15:0];
        return q[1] ? -$signed(v) : $signed(v);
    endfunction

endpackage

/* rtl/core/mdcm_ctrl.sv */
// controller state machine for the chorus mixer
module mdcm_ctrl
    import mdcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  mdcm_stat_t stat,
    output mdcm_cmd_t  cmd
);

    mdcm_state_t state_reg;
    mdcm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.modulate = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_WET;
            end
            S_WET:
            begin
                cmd.blend = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/mdcm_dp.sv */
// datapath: gain, sine lookup, delay lines, interpolation, blend and final mix
module mdcm_dp
    import mdcm_pkg::*;
#(
    parameter int DELAY_DEPTH     = 2048,
    parameter int SINE_TABLE_SIZE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mdcm_cmd_t   cmd,
    output mdcm_stat_t  stat,
    input  logic [63:0] in_data,
    input  logic [15:0] input_gain,
    input  logic [15:0] drift_depth,
    input  logic [15:0] wobble_depth,
    input  logic [14:0] effect_mix,
    input  logic [23:0] drift_step,
    input  logic [23:0] wobble_step,
    output logic [31:0] out_data,
    output logic        out_valid,
    input  logic        out_ready
);

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int SINE_W = $clog2(SINE_TABLE_SIZE);

    // constant sine table
    logic signed [15:0] sine_rom [SINE_TABLE_SIZE];
    for (genvar g = 0; g < SINE_TABLE_SIZE; g++)
    begin : g_sine
        assign sine_rom[g] = sine_entry(g, SINE_W);
    end

    // delay lines
    logic signed [15:0] line_l [DELAY_DEPTH];
    logic signed [15:0] line_r [DELAY_DEPTH];

    logic signed [15:0] in_l_reg, in_r_reg, eff_l_reg, eff_r_reg;
    logic signed [15:0] scaled_l_reg, scaled_r_reg;
    logic signed [15:0] sd_reg, sw_reg;
    logic               active_reg;
    logic [14:0]        wet_reg;
    logic signed [32:0] pd_reg, pw_reg;
    logic [15:0]        frac_reg;
    logic signed [15:0] t1_l_reg, t2_l_reg, t1_r_reg, t2_r_reg;
    logic signed [15:0] delayed_l_reg, delayed_r_reg;
    logic signed [15:0] proc_l_reg, proc_r_reg;
    logic signed [15:0] out_l_reg, out_r_reg;
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [23:0]        drift_phase_reg, wobble_phase_reg;

    // input gain
    logic signed [16:0] gain_ext;
    logic signed [32:0] gprod_l, gprod_r;
    logic signed [15:0] scaled_l_next, scaled_r_next;
    assign gain_ext = $signed({1'b0, input_gain});
    assign gprod_l = $signed(in_data[15:0]) * gain_ext;
    assign gprod_r = $signed(in_data[31:16]) * gain_ext;
    assign scaled_l_next = sat16(40'((gprod_l + 33'sd8192) >>> 14));
    assign scaled_r_next = sat16(40'((gprod_r + 33'sd8192) >>> 14));

    // wet level, divide by five through the reciprocal
    logic [18:0] wsum;
    logic [38:0] wet_prod;
    logic [16:0] wet_q;
    logic [14:0] wet_next;
    logic        active_next;
    assign wsum = {({1'b0, drift_depth} + {1'b0, wobble_depth}), 1'b0} + 19'd2;
    assign wet_prod = wsum * WET_RECIP;
    assign wet_q = wet_prod[38:22];
    assign wet_next = (wet_q > 17'd16384) ? WET_MAX : wet_q[14:0];
    assign active_next = (drift_depth > ACTIVE_THRESHOLD) || (wobble_depth > ACTIVE_THRESHOLD);

    // delay in Q16 and tap addresses
    logic signed [39:0] mod_sum;
    logic signed [39:0] delay_q16;
    logic [39:0]        delay_c;
    logic [ADDR_W-1:0]  tap1, tap2;
    assign mod_sum = 40'(pd_reg) * 40'sd20 + 40'(pw_reg) * 40'sd50;
    assign delay_q16 = DELAY_BASE + (mod_sum >>> 11);
    assign delay_c = delay_q16[39] ? 40'd0 : delay_q16;
    assign tap1 = wp_reg - delay_c[16 +: ADDR_W];
    assign tap2 = tap1 - ADDR_W'(1);

    // linear interpolation
    logic [16:0]        w1;
    logic signed [35:0] iacc_l, iacc_r, irnd_l, irnd_r;
    assign w1 = 17'd65536 - {1'b0, frac_reg};
    assign iacc_l = t1_l_reg * $signed({1'b0, w1}) + t2_l_reg * $signed({2'b0, frac_reg});
    assign iacc_r = t1_r_reg * $signed({1'b0, w1}) + t2_r_reg * $signed({2'b0, frac_reg});
    assign irnd_l = (iacc_l + 36'sd32768) >>> 16;
    assign irnd_r = (iacc_r + 36'sd32768) >>> 16;

    // wet blend
    logic [15:0]        dry_w;
    logic signed [34:0] bacc_l, bacc_r, brnd_l, brnd_r;
    logic signed [15:0] proc_l_next, proc_r_next;
    assign dry_w = 16'd32768 - {1'b0, wet_reg};
    assign bacc_l = scaled_l_reg * $signed({1'b0, dry_w})
                  + delayed_l_reg * $signed({2'b0, wet_reg});
    assign bacc_r = scaled_r_reg * $signed({1'b0, dry_w})
                  + delayed_r_reg * $signed({2'b0, wet_reg});
    assign brnd_l = (bacc_l + 35'sd16384) >>> 15;
    assign brnd_r = (bacc_r + 35'sd16384) >>> 15;
    assign proc_l_next = active_reg ? brnd_l[15:0] : scaled_l_reg;
    assign proc_r_next = active_reg ? brnd_r[15:0] : scaled_r_reg;

    // final mix with the effect sample
    logic [15:0]        mix_w;
    logic signed [16:0] sum_l, sum_r;
    logic signed [35:0] macc_l, macc_r;
    assign mix_w = 16'd32768 - {1'b0, effect_mix};
    assign sum_l = 17'(in_l_reg) + 17'(proc_l_reg);
    assign sum_r = 17'(in_r_reg) + 17'(proc_r_reg);
    assign macc_l = sum_l * $signed({1'b0, mix_w}) + eff_l_reg * $signed({2'b0, effect_mix});
    assign macc_r = sum_r * $signed({1'b0, mix_w}) + eff_r_reg * $signed({2'b0, effect_mix});

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_l_reg <= $signed(in_data[15:0]);
            in_r_reg <= $signed(in_data[31:16]);
            eff_l_reg <= $signed(in_data[47:32]);
            eff_r_reg <= $signed(in_data[63:48]);
            scaled_l_reg <= scaled_l_next;
            scaled_r_reg <= scaled_r_next;
            sd_reg <= sine_rom[drift_phase_reg[23 -: SINE_W]];
            sw_reg <= sine_rom[wobble_phase_reg[23 -: SINE_W]];
            wet_reg <= wet_next;
            active_reg <= active_next;
        end
        if (cmd.modulate)
        begin
            pd_reg <= sd_reg * $signed({1'b0, drift_depth});
            pw_reg <= sw_reg * $signed({1'b0, wobble_depth});
        end
        if (cmd.addr)
            frac_reg <= delay_c[15:0];
        if (cmd.interp)
        begin
            delayed_l_reg <= irnd_l[15:0];
            delayed_r_reg <= irnd_r[15:0];
        end
        if (cmd.blend)
        begin
            proc_l_reg <= proc_l_next;
            proc_r_reg <= proc_r_next;
        end
        if (cmd.finish)
        begin
            out_l_reg <= sat16(40'((macc_l + 36'sd16384) >>> 15));
            out_r_reg <= sat16(40'((macc_r + 36'sd16384) >>> 15));
        end
    end

    // left delay line: clear sweep or sample write, two tap reads
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            line_l[clr_addr_reg] <= 16'sd0;
        else if (cmd.modulate && active_reg)
            line_l[wp_reg] <= scaled_l_reg;
        if (cmd.addr)
        begin
            t1_l_reg <= line_l[tap1];
            t2_l_reg <= line_l[tap2];
        end
    end

    // right delay line
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            line_r[clr_addr_reg] <= 16'sd0;
        else if (cmd.modulate && active_reg)
            line_r[wp_reg] <= scaled_r_reg;
        if (cmd.addr)
        begin
            t1_r_reg <= line_r[tap1];
            t2_r_reg <= line_r[tap2];
        end
    end

    // control state: positions, phases, clear sweep, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            clr_addr_reg <= '0;
            drift_phase_reg <= '0;
            wobble_phase_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cmd.finish)
            begin
                wp_reg <= wp_reg + ADDR_W'(1);
                drift_phase_reg <= drift_phase_reg + drift_step;
                wobble_phase_reg <= wobble_phase_reg + wobble_step;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.clear_last = (clr_addr_reg == {ADDR_W{1'b1}});
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = {out_r_reg, out_l_reg};

endmodule

/* rtl/core/modulated_delay_chorus_mixer.sv */
// top level: configuration registers, controller and datapath of the chorus mixer
//
// Stereo chorus with a modulated fractional delay and an effect mix. Each item
// passes through the accept step (gain and sine lookup) followed by five
// datapath steps (modulation products and line write, tap read, interpolation,
// wet blend, final mix); the shared delay-line ports and the registered sine
// table set this order. The final mix waits while the last result is not taken.
// A finished result waits in the output register while the block takes the next
// item. After reset the block clears both delay lines, one entry per cycle, and
// accepts no item until that sweep is done; configuration writes are taken
// during that time. DELAY_DEPTH and SINE_TABLE_SIZE must be powers of two.
module modulated_delay_chorus_mixer
    import mdcm_pkg::*;
#(
    parameter int DELAY_DEPTH     = 2048,
    parameter int SINE_TABLE_SIZE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // left_in, right_in, effect_left, effect_right
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_out, right_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] gain_reg, drift_depth_reg, wobble_depth_reg;
    logic [14:0] mix_reg;
    logic [23:0] drift_step_reg, wobble_step_reg;
    logic        cfg_write;
    logic [2:0]  cfg_sel;

    mdcm_cmd_t  cmd;
    mdcm_stat_t stat;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            drift_depth_reg <= '0;
            wobble_depth_reg <= '0;
            mix_reg <= MIX_RESET;
            drift_step_reg <= DRIFT_STEP_RESET;
            wobble_step_reg <= WOBBLE_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_INPUT_GAIN:   gain_reg <= pwdata[15:0];
                REG_DRIFT_DEPTH:  drift_depth_reg <= pwdata[15:0];
                REG_WOBBLE_DEPTH: wobble_depth_reg <= pwdata[15:0];
                REG_EFFECT_MIX:   mix_reg <= pwdata[14:0];
                REG_DRIFT_STEP:   drift_step_reg <= pwdata[23:0];
                REG_WOBBLE_STEP:  wobble_step_reg <= pwdata[23:0];
                default:          ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_sel)
            REG_INPUT_GAIN:   prdata = {16'd0, gain_reg};
            REG_DRIFT_DEPTH:  prdata = {16'd0, drift_depth_reg};
            REG_WOBBLE_DEPTH: prdata = {16'd0, wobble_depth_reg};
            REG_EFFECT_MIX:   prdata = {17'd0, mix_reg};
            REG_DRIFT_STEP:   prdata = {8'd0, drift_step_reg};
            REG_WOBBLE_STEP:  prdata = {8'd0, wobble_step_reg};
            default:          prdata = 32'd0;
        endcase
    end

    mdcm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mdcm_dp #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_data      (s_axis_tdata),
        .input_gain   (gain_reg),
        .drift_depth  (drift_depth_reg),
        .wobble_depth (wobble_depth_reg),
        .effect_mix   (mix_reg),
        .drift_step   (drift_step_reg),
        .wobble_step  (wobble_step_reg),
        .out_data     (m_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready)
    );

    // one item at a time: no second accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous item in progress");

    // a new result appears exactly when the controller returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result loaded without controller returning to idle");

    // the result register is only loaded when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result overwritten before it was taken");

endmodule

/* tb/sv/mdcm_checker.sv */
// checker for the chorus mixer: tracks register writes, predicts each output item and compares
module mdcm_checker
    import mdcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // left_in, right_in, effect_left, effect_right
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // left_out, right_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          frames_pending
);

    localparam int LINE_LEN = 2048;
    localparam int SINE_LEN = 1024;

    // predictor state and register copies
    logic [15:0] gain_q;
    logic [15:0] drift_q;
    logic [15:0] wobble_q;
    logic [14:0] mix_q;
    logic [23:0] drift_step_q;
    logic [23:0] wobble_step_q;
    logic [23:0] drift_ph;
    logic [23:0] wobble_ph;
    int          wr_pos;
    logic signed [15:0] line_left [LINE_LEN];
    logic signed [15:0] line_right [LINE_LEN];
    int          sine_lut [SINE_LEN];
    logic [31:0] out_frames [$];

    function automatic longint clip16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // round half up then arithmetic shift
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // one side: gain, delay line write and interpolated read, wet blend, effect mix
    function automatic longint mix_side(input bit right, input longint smp, input longint eff,
                                        input bit active, input longint dly, input longint wet);
        longint scaled;
        longint proc;
        longint dint;
        longint frac;
        longint t1;
        longint t2;
        longint delayed;
        int     r1;
        int     r2;
        scaled = clip16(rnd_shift(smp * longint'(gain_q), 14));
        proc = scaled;
        if (active)
        begin
            if (right)
                line_right[wr_pos] = scaled[15:0];
            else
                line_left[wr_pos] = scaled[15:0];
            dint = dly >>> 16;
            frac = dly & 64'hFFFF;
            r1 = (wr_pos - int'(dint % LINE_LEN) + LINE_LEN) % LINE_LEN;
            r2 = (r1 + LINE_LEN - 1) % LINE_LEN;
            t1 = right ? line_right[r1] : line_left[r1];
            t2 = right ? line_right[r2] : line_left[r2];
            delayed = rnd_shift(t1 * (65536 - frac) + t2 * frac, 16);
            proc = rnd_shift(scaled * (32768 - wet) + delayed * wet, 15);
        end
        return clip16(rnd_shift((smp + proc) * (32768 - longint'(mix_q))
                                + eff * longint'(mix_q), 15));
    endfunction

    // predict one output frame and advance phases and write position
    function automatic logic [31:0] chorus_frame(input logic [63:0] d);
        longint sd;
        longint sw;
        longint modv;
        longint dly;
        longint wet;
        longint lo;
        longint ro;
        bit     active;
        sd = sine_lut[drift_ph[23:14]];
        sw = sine_lut[wobble_ph[23:14]];
        active = (drift_q > ACTIVE_THRESHOLD) || (wobble_q > ACTIVE_THRESHOLD);
        modv = 20 * sd * longint'(drift_q) + 50 * sw * longint'(wobble_q);
        dly = (64'sd10 <<< 16) + (modv >>> 11);
        if (dly < 0)
            dly = 0;
        wet = ((longint'(drift_q) + longint'(wobble_q)) * 2 + 2) / 5;
        if (wet > 16384)
            wet = 16384;
        lo = mix_side(1'b0, longint'($signed(d[15:0])), longint'($signed(d[47:32])),
                      active, dly, wet);
        ro = mix_side(1'b1, longint'($signed(d[31:16])), longint'($signed(d[63:48])),
                      active, dly, wet);
        drift_ph = drift_ph + drift_step_q;
        wobble_ph = wobble_ph + wobble_step_q;
        wr_pos = (wr_pos + 1) % LINE_LEN;
        return {ro[15:0], lo[15:0]};
    endfunction

    // quarter wave sine table, Q1.15
    initial
    begin
        bit [63:0] four;
        bit [63:0] q;
        bit [63:0] f;
        bit [63:0] t;
        bit [63:0] t2;
        bit [63:0] r;
        bit [63:0] s;
        for (int i = 0; i < SINE_LEN; i++)
        begin
            four = 64'(i) * 4;
            q = four / SINE_LEN;
            f = four % SINE_LEN;
            if (q[0])
                f = SINE_LEN - f;
            t = (f << 30) / SINE_LEN;
            t2 = (t * t) >> 30;
            r = 64'd85569278 - ((64'd5026938 * t2) >> 30);
            r = 64'd693598671 - ((r * t2) >> 30);
            r = 64'd1686629713 - ((r * t2) >> 30);
            s = (((r * t) >> 30) + 64'd16384) >> 15;
            if (s > 64'd32767)
                s = 64'd32767;
            sine_lut[i] = q[1] ? -int'(s) : int'(s);
        end
    end

    // watch the channels
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            gain_q <= GAIN_RESET;
            drift_q <= '0;
            wobble_q <= '0;
            mix_q <= MIX_RESET;
            drift_step_q <= DRIFT_STEP_RESET;
            wobble_step_q <= WOBBLE_STEP_RESET;
            drift_ph = '0;
            wobble_ph = '0;
            wr_pos = 0;
            for (int i = 0; i < LINE_LEN; i++)
            begin
                line_left[i] = '0;
                line_right[i] = '0;
            end
            out_frames.delete();
            fail_count <= 0;
            frames_pending <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_INPUT_GAIN:   gain_q <= pwdata[15:0];
                    REG_DRIFT_DEPTH:  drift_q <= pwdata[15:0];
                    REG_WOBBLE_DEPTH: wobble_q <= pwdata[15:0];
                    REG_EFFECT_MIX:   mix_q <= pwdata[14:0];
                    REG_DRIFT_STEP:   drift_step_q <= pwdata[23:0];
                    REG_WOBBLE_STEP:  wobble_step_q <= pwdata[23:0];
                    default: ;
                endcase
            end
            // input item accepted
            if (s_axis_tvalid && s_axis_tready)
                out_frames.push_back(chorus_frame(s_axis_tdata));
            // output item accepted
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (out_frames.size() == 0)
                begin
                    $display("%0t: unexpected output item %h", $time, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = out_frames.pop_front();
                    if (want[15:0] !== m_axis_tdata[15:0] || want[31:16] !== m_axis_tdata[31:16])
                    begin
                        $display("%0t: left_out exp %0d got %0d, right_out exp %0d got %0d",
                                 $time, $signed(want[15:0]), $signed(m_axis_tdata[15:0]),
                                 $signed(want[31:16]), $signed(m_axis_tdata[31:16]));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            frames_pending <= out_frames.size();
        end
    end

endmodule

/* tb/sv/tb_modulated_delay_chorus_mixer.sv */
// testbench top for the chorus mixer: clock, reset, stimulus and verdict
module tb_modulated_delay_chorus_mixer;
    import mdcm_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // left_in, right_in, effect_left, effect_right
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // left_out, right_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          frames_pending;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          cycles;

    modulated_delay_chorus_mixer dut (.*);

    mdcm_checker chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** modulated_delay_chorus_mixer: FAILED **");
            $finish;
        end
    end

    // one register write, setup then access
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // wait until all outputs are back and the datapath has drained
    task automatic drain();
        idle_sender();
        while (frames_pending != 0 || s_axis_tvalid)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_regs(input logic [31:0] g, input logic [31:0] dd, input logic [31:0] wd,
                            input logic [31:0] mx, input logic [31:0] ds, input logic [31:0] ws);
        drain();
        reg_write(REG_INPUT_GAIN, g);
        reg_write(REG_DRIFT_DEPTH, dd);
        reg_write(REG_WOBBLE_DEPTH, wd);
        reg_write(REG_EFFECT_MIX, mx);
        reg_write(REG_DRIFT_STEP, ds);
        reg_write(REG_WOBBLE_STEP, ws);
    endtask

    // present one frame, with random idle cycles in front
    task automatic send_frame(input logic [15:0] l, input logic [15:0] r,
                              input logic [15:0] el, input logic [15:0] er);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {er, el, r, l};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd4;
            2: return 32'd5;
            3: return 32'd40960;
            4: return $urandom;
            default: return $urandom_range(40960);
        endcase
    endfunction

    function automatic logic [31:0] pick_reg(input int hi);
        if ($urandom_range(5) == 0)
            return $urandom;
        return $urandom_range(hi);
    endfunction

    // stimulus
    initial
    begin
        logic [15:0] ext [4];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, extreme samples
        for (int i = 0; i < 4; i++)
            send_frame(ext[i], ext[3 - i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
        // strong settings: double gain, depths at the wet limit, half mix, fast phases
        set_regs(32'd32768, 32'd40960, 32'd40960, 32'd16384, 32'hFFFFFF, 32'h123457);
        for (int i = 0; i < 8; i++)
            send_frame(ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i / 2]);
        // threshold edge, depth just below activity, zero gain and mix
        set_regs(32'd0, 32'd4, 32'd4, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 3; i++)
            send_frame(ext[i], ext[i + 1], ext[3 - i], ext[i]);
        // first active depth, writes past the last register are ignored
        set_regs(32'd16384, 32'd5, 32'd0, 32'd1081, 32'd65536, 32'd0);
        reg_write(3'd6, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_frame(ext[i], ext[(i + 2) % 4], ext[i], ext[3 - i]);

        // random phases, idle mode cycles through the four patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_sender();
            set_regs(pick_reg(32768), pick_depth(), pick_depth(), pick_reg(16384),
                     $urandom, $urandom);
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 77; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 77; end
                default: begin send_gap_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int i = 0; i < 225; i++)
            begin
                // hold off once until all outputs are back
                if (ph == 2 && i == 100)
                begin
                    idle_sender();
                    while (frames_pending != 0)
                        @(negedge clk);
                end
                send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            end
        end
        idle_sender();
        recv_stall_pct = 0;

        while (frames_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("** modulated_delay_chorus_mixer: PASSED **");
        else
            $display("** modulated_delay_chorus_mixer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mdcm_pkg.sv
rtl/core/mdcm_ctrl.sv
rtl/core/mdcm_dp.sv
rtl/core/modulated_delay_chorus_mixer.sv
tb/sv/mdcm_checker.sv
tb/sv/tb_modulated_delay_chorus_mixer.sv
